// ===== hdl/srce_pkg.sv =====
// ----------------------------------------------------------------------------
// srce_pkg: shared definitions for the sorted range count engine
// Store depth, derived widths, request and state codes, and the structures
// that pass between the sequencer and the point memory.
// ----------------------------------------------------------------------------
package srce_pkg;

	localparam int MAX_POINTS = 4096;
	localparam int ADDR_W     = $clog2(MAX_POINTS);
	localparam int CNT_W      = $clog2(MAX_POINTS + 1);
	localparam int OUT_W      = 13;
	localparam int KEY_W      = 32;

	typedef enum logic [1:0] {
		REQ_LOAD  = 2'd0,
		REQ_QUERY = 2'd1,
		REQ_CLEAR = 2'd2
	} req_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SRCH,
		ST_CMP,
		ST_SHIFT,
		ST_PUT,
		ST_RESULT
	} state_t;

	typedef struct packed {
		logic              we;
		logic [ADDR_W-1:0] waddr;
		logic [KEY_W-1:0]  wdata;
		logic              re;
		logic [ADDR_W-1:0] raddr;
	} mem_req_t;

	typedef struct packed {
		logic             valid;
		logic [OUT_W-1:0] count;
	} result_t;

	typedef struct packed {
		logic             busy;
		logic [CNT_W-1:0] stored;
	} status_t;

	// Flipping the sign bit turns signed order into unsigned order.
	function automatic logic [KEY_W-1:0] to_key(input logic signed [KEY_W-1:0] v);
		to_key = {~v[KEY_W-1], v[KEY_W-2:0]};
	endfunction

endpackage

// ===== hdl/srce_mem.sv =====
// ----------------------------------------------------------------------------
// srce_mem: point store
// One write port and one read port with a registered read, holding the
// sorted point keys.
// ----------------------------------------------------------------------------
module srce_mem
	import srce_pkg::*;
(
	input  logic             clk,
	input  mem_req_t         req,
	output logic [KEY_W-1:0] rd_data
);

	logic [KEY_W-1:0] mem_q [MAX_POINTS];

	always_ff @(posedge clk) begin
		if (req.we) begin
			mem_q[req.waddr] <= req.wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (req.re) begin
			rd_data <= mem_q[req.raddr];
		end
	end

endmodule

// ===== hdl/srce_ctrl.sv =====
// ----------------------------------------------------------------------------
// srce_ctrl: search and insert sequencer
// Runs lower-bound and upper-bound binary searches through one shared compare unit and
// shifts the store up by one entry a cycle to make room for a new point.
// ----------------------------------------------------------------------------
module srce_ctrl
	import srce_pkg::*;
(
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	output logic                    in_stall,
	input  logic [1:0]              req_type,
	input  logic signed [KEY_W-1:0] point_value,
	input  logic signed [KEY_W-1:0] range_low,
	input  logic signed [KEY_W-1:0] range_high,
	input  logic                    out_free,
	output result_t                 res,
	output mem_req_t                mreq,
	input  logic [KEY_W-1:0]        rd_data,
	output status_t                 status
);

	state_t           state_q, state_d;
	logic [CNT_W-1:0] cnt_q, cnt_d;
	logic [CNT_W-1:0] lo_q, lo_d;
	logic [CNT_W-1:0] hi_q, hi_d;
	logic [CNT_W-1:0] a_q, a_d;
	logic [CNT_W-1:0] pos_q, pos_d;
	logic [CNT_W-1:0] idx_q, idx_d;
	logic [CNT_W-1:0] res_q, res_d;
	logic [KEY_W-1:0] key_q, key_d;
	logic [KEY_W-1:0] high_q, high_d;
	logic             strict_q, strict_d;
	logic             query_q, query_d;

	logic [CNT_W-1:0]       mid;
	logic [CNT_W-1:0]       idx_m1;
	logic [CNT_W-1:0]       idx_m2;
	logic [CNT_W-1:0]       cnt_m1;
	logic                   below;
	logic [KEY_W-1:0]       low_key;
	logic [KEY_W-1:0]       high_key;
	logic [CNT_W+OUT_W-1:0] res_wide;

	assign mid      = lo_q + ((hi_q - lo_q) >> 1);
	assign idx_m1   = idx_q - CNT_W'(1);
	assign idx_m2   = idx_q - CNT_W'(2);
	assign cnt_m1   = cnt_q - CNT_W'(1);
	assign below    = strict_q ? (rd_data <= key_q) : (rd_data < key_q);
	assign low_key  = to_key(range_low);
	assign high_key = to_key(range_high);
	assign res_wide = {{OUT_W{1'b0}}, res_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
		end
	end

	always_ff @(posedge clk) begin
		lo_q     <= lo_d;
		hi_q     <= hi_d;
		a_q      <= a_d;
		pos_q    <= pos_d;
		idx_q    <= idx_d;
		res_q    <= res_d;
		key_q    <= key_d;
		high_q   <= high_d;
		strict_q <= strict_d;
		query_q  <= query_d;
	end

	always_comb begin
		state_d   = state_q;
		cnt_d     = cnt_q;
		lo_d      = lo_q;
		hi_d      = hi_q;
		a_d       = a_q;
		pos_d     = pos_q;
		idx_d     = idx_q;
		res_d     = res_q;
		key_d     = key_q;
		high_d    = high_q;
		strict_d  = strict_q;
		query_d   = query_q;
		mreq      = '0;
		res.valid = 1'b0;
		res.count = res_wide[OUT_W-1:0];
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					unique case (req_type)
						REQ_LOAD: begin
							if (cnt_q != CNT_W'(MAX_POINTS)) begin
								key_d    = to_key(point_value);
								lo_d     = '0;
								hi_d     = cnt_q;
								strict_d = 1'b1;
								query_d  = 1'b0;
								state_d  = ST_SRCH;
							end
						end
						REQ_QUERY: begin
							if (low_key > high_key) begin
								res_d   = '0;
								state_d = ST_RESULT;
							end else begin
								key_d    = low_key;
								high_d   = high_key;
								lo_d     = '0;
								hi_d     = cnt_q;
								strict_d = 1'b0;
								query_d  = 1'b1;
								state_d  = ST_SRCH;
							end
						end
						REQ_CLEAR: begin
							cnt_d = '0;
						end
						default: begin
						end
					endcase
				end
			end
			ST_SRCH: begin
				if (lo_q < hi_q) begin
					mreq.re    = 1'b1;
					mreq.raddr = mid[ADDR_W-1:0];
					state_d    = ST_CMP;
				end else if (!query_q) begin
					pos_d = lo_q;
					if (lo_q == cnt_q) begin
						state_d = ST_PUT;
					end else begin
						mreq.re    = 1'b1;
						mreq.raddr = cnt_m1[ADDR_W-1:0];
						idx_d      = cnt_q;
						state_d    = ST_SHIFT;
					end
				end else if (!strict_q) begin
					a_d      = lo_q;
					lo_d     = '0;
					hi_d     = cnt_q;
					strict_d = 1'b1;
					key_d    = high_q;
				end else begin
					res_d   = lo_q - a_q;
					state_d = ST_RESULT;
				end
			end
			ST_CMP: begin
				if (below) begin
					lo_d = mid + CNT_W'(1);
				end else begin
					hi_d = mid;
				end
				state_d = ST_SRCH;
			end
			ST_SHIFT: begin
				mreq.we    = 1'b1;
				mreq.waddr = idx_q[ADDR_W-1:0];
				mreq.wdata = rd_data;
				if (idx_m1 == pos_q) begin
					state_d = ST_PUT;
				end else begin
					mreq.re    = 1'b1;
					mreq.raddr = idx_m2[ADDR_W-1:0];
					idx_d      = idx_m1;
				end
			end
			ST_PUT: begin
				mreq.we    = 1'b1;
				mreq.waddr = pos_q[ADDR_W-1:0];
				mreq.wdata = key_q;
				cnt_d      = cnt_q + CNT_W'(1);
				state_d    = ST_IDLE;
			end
			ST_RESULT: begin
				res.valid = out_free;
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	assign in_stall      = (state_q != ST_IDLE);
	assign status.busy   = (state_q != ST_IDLE);
	assign status.stored = cnt_q;

endmodule

// ===== hdl/sorted_range_count_engine_unit.sv =====
// ----------------------------------------------------------------------------
// sorted_range_count_engine_unit: sorted point store with range counting
// Holds up to 4096 signed points in ascending order and counts the points
// that lie in a closed range.
// ----------------------------------------------------------------------------
// A load, clear or unknown request that causes no work is taken without
// leaving the idle state. A query runs two binary searches; each probe
// reads through the single memory read port in ST_SRCH and compares in
// ST_CMP; ST_SRCH keeps the first bound between the two searches, and the
// count passes through ST_RESULT to the output register. A query whose low
// bound lies above its high bound skips the searches and goes to ST_RESULT
// with a count of zero. A load searches once and then moves every larger
// point up by one entry, one per cycle, before ST_PUT writes the new point.
// While the block works on an item in_stall is high; a finished count waits
// in the output register and does not hold up the next transfer.
module sorted_range_count_engine_unit
	import srce_pkg::*;
(
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	output logic                    in_stall,
	input  logic [1:0]              req_type,
	input  logic signed [KEY_W-1:0] point_value,
	input  logic signed [KEY_W-1:0] range_low,
	input  logic signed [KEY_W-1:0] range_high,
	output logic                    out_valid,
	input  logic                    out_stall,
	output logic [OUT_W-1:0]        point_count_in_range
);

	mem_req_t         mreq;
	logic [KEY_W-1:0] rd_data;
	result_t          res;
	status_t          status;
	logic             out_valid_q;
	logic [OUT_W-1:0] out_count_q;
	logic             out_free;

	assign out_free = !out_valid_q || !out_stall;

	srce_mem u_mem (
		.clk     (clk),
		.req     (mreq),
		.rd_data (rd_data)
	);

	srce_ctrl u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.req_type    (req_type),
		.point_value (point_value),
		.range_low   (range_low),
		.range_high  (range_high),
		.out_free    (out_free),
		.res         (res),
		.mreq        (mreq),
		.rd_data     (rd_data),
		.status      (status)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res.valid) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res.valid) begin
			out_count_q <= res.count;
		end
	end

	assign out_valid            = out_valid_q;
	assign point_count_in_range = out_count_q;

	assert property (@(posedge clk) disable iff (!arst_n)
		!(res.valid && out_valid_q && out_stall))
		else $error("Result launched while a stalled result was still held.");

	assert property (@(posedge clk) disable iff (!arst_n)
		status.stored <= CNT_W'(MAX_POINTS))
		else $error("Stored point count exceeds the store depth.");

	assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall && req_type == REQ_LOAD
			&& status.stored == CNT_W'(MAX_POINTS))
		|=> (status.stored == CNT_W'(MAX_POINTS) && !status.busy))
		else $error("A load into a full store was not dropped.");

	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(res.valid))
		else $error("Output became valid without a result from the sequencer.");

	assert property (@(posedge clk) disable iff (!arst_n)
		(mreq.we || mreq.re) |-> status.busy)
		else $error("Memory accessed while the sequencer was idle.");

endmodule
